/* design/midi_event_byte_serializer_macros.svh */
// Assertion macros for the MIDI event byte serializer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef MIDI_EVENT_BYTE_SERIALIZER_MACROS_SVH
`define MIDI_EVENT_BYTE_SERIALIZER_MACROS_SVH

// Same-cycle implication.
`define MEBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MEBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mebs_pkg.sv */
// Package for the MIDI event byte serializer: types, event codes, constants.
// No dependencies.
package mebs_pkg;

    localparam int DELTA_W   = 28;
    localparam int GROUP_W   = 7;
    localparam int BPM_W     = 10;
    localparam int QUO_W     = 26;
    localparam int REM_W     = 10;
    localparam int DIV_STEPS = 26;

    localparam logic [QUO_W-1:0] USEC_PER_MINUTE = 26'd60000000;
    localparam logic [4:0]       DIV_LAST        = 5'(DIV_STEPS - 1);

    localparam logic [3:0] NOTE_ON_HI   = 4'h9;
    localparam logic [3:0] NOTE_OFF_HI  = 4'h8;
    localparam logic [7:0] META_PREFIX  = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] TEMPO_LEN    = 8'h03;
    localparam logic [7:0] TIMESIG_LEN  = 8'h04;

    localparam logic [2:0] BODY_LAST_NOTE    = 3'd2;
    localparam logic [2:0] BODY_LAST_TEMPO   = 3'd5;
    localparam logic [2:0] BODY_LAST_TIMESIG = 3'd6;

    localparam logic [7:0] CLOCKS_PER_CLICK_RST = 8'd24;
    localparam logic [7:0] THIRTY_SECONDS_RST   = 8'd8;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_TEMPO    = 2'd2,
        OP_TIMESIG  = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_CLOCKS_PER_CLICK = 1'b0,
        CFG_THIRTY_SECONDS   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_VLQ,
        ST_BODY
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [BPM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // Smallest denominators whose square passes 2^(2j+1).
    typedef logic [7:0] den_step_arr_t [8];
    localparam den_step_arr_t DEN_STEP =
        '{8'd2, 8'd3, 8'd6, 8'd12, 8'd23, 8'd46, 8'd91, 8'd182};

    function automatic logic [3:0] denom_exponent(input logic [7:0] den);
        logic [3:0] k;
        k = '0;
        for (int j = 0; j < 8; j++) begin
            if (den >= DEN_STEP[j])
            begin
                k = k + 4'd1;
            end
        end
        return k;
    endfunction

endpackage

/* design/mebs_ifs.sv */
// Channel interfaces of the MIDI event byte serializer.
// Depends on mebs_pkg.
interface mebs_event_if;
    import mebs_pkg::*;
    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [DELTA_W-1:0]   delta_time;
    logic [3:0]           channel;
    logic [6:0]           pitch;
    logic [6:0]           velocity;
    logic [BPM_W-1:0]     tempo_bpm;
    logic [7:0]           numerator;
    logic [7:0]           denominator;

    modport source (output valid, operation, delta_time, channel, pitch, velocity,
                    tempo_bpm, numerator, denominator, input ready);
    modport sink (input valid, operation, delta_time, channel, pitch, velocity,
                  tempo_bpm, numerator, denominator, output ready);
endinterface

interface mebs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

interface mebs_cfg_if;
    import mebs_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/mebs_divider.sv */
// Restoring divider: 60000000 / divisor, one quotient bit per cycle.
// Depends on mebs_pkg.
module mebs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  mebs_pkg::div_req_t req,
    output mebs_pkg::div_rsp_t rsp
);
    import mebs_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] qr_reg, qr_next;
    logic [BPM_W-1:0] div_reg, div_next;

    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder, subtract if it fits.
    assign trial = {rem_reg, qr_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qr_next   = qr_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            qr_next   = USEC_PER_MINUTE;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
            qr_next  = {qr_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qr_reg  <= qr_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = qr_reg;

endmodule

/* design/mebs_sequencer.sv */
// Byte sequencer: captures an event, emits VLQ delta then body bytes.
// Depends on mebs_pkg and mebs_ifs; drives the divider.
module mebs_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    mebs_event_if.sink         evt,
    mebs_byte_if.source        stream,
    input  logic [7:0]         clocks_per_click,
    input  logic [7:0]         thirty_seconds_per_quarter,
    output mebs_pkg::div_req_t div_req,
    input  mebs_pkg::div_rsp_t div_rsp
);
    import mebs_pkg::*;

    seq_state_t         state_reg, state_next;
    op_t                op_reg;
    logic [3:0]         chan_reg;
    logic [6:0]         pitch_reg;
    logic [6:0]         vel_reg;
    logic [7:0]         num_reg;
    logic [3:0]         exp_reg;
    logic [DELTA_W-1:0] vlq_reg, vlq_next;
    logic [1:0]         vlq_cnt_reg, vlq_cnt_next;
    logic [2:0]         idx_reg, idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               emit_ok;
    logic               emit;
    logic [7:0]         emit_byte;
    logic               emit_last;
    logic [7:0]         body_byte;
    logic [2:0]         body_last_idx;
    logic [1:0]         groups_m1;

    assign accept  = evt.valid && evt.ready;
    assign emit_ok = !out_valid_reg || stream.ready;

    // Number of 7-bit groups minus one.
    always_comb
    begin
        if (evt.delta_time[27:21] != '0)
            groups_m1 = 2'd3;
        else if (evt.delta_time[20:14] != '0)
            groups_m1 = 2'd2;
        else if (evt.delta_time[13:7] != '0)
            groups_m1 = 2'd1;
        else
            groups_m1 = 2'd0;
    end

    always_comb
    begin
        case (op_reg)
            OP_NOTE_ON, OP_NOTE_OFF: body_last_idx = BODY_LAST_NOTE;
            OP_TEMPO:                body_last_idx = BODY_LAST_TEMPO;
            default:                 body_last_idx = BODY_LAST_TIMESIG;
        endcase
    end

    always_comb
    begin
        body_byte = '0;
        case (op_reg)
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                case (idx_reg)
                    3'd0:    body_byte = {(op_reg == OP_NOTE_ON) ? NOTE_ON_HI : NOTE_OFF_HI,
                                          chan_reg};
                    3'd1:    body_byte = {1'b0, pitch_reg};
                    default: body_byte = {1'b0, vel_reg};
                endcase
            end
            OP_TEMPO:
            begin
                case (idx_reg)
                    3'd0:    body_byte = META_PREFIX;
                    3'd1:    body_byte = META_TEMPO;
                    3'd2:    body_byte = TEMPO_LEN;
                    3'd3:    body_byte = {6'd0, div_rsp.quotient[25:24]} & 8'h00
                                         | div_rsp.quotient[23:16];
                    3'd4:    body_byte = div_rsp.quotient[15:8];
                    default: body_byte = div_rsp.quotient[7:0];
                endcase
            end
            default:
            begin
                case (idx_reg)
                    3'd0:    body_byte = META_PREFIX;
                    3'd1:    body_byte = META_TIMESIG;
                    3'd2:    body_byte = TIMESIG_LEN;
                    3'd3:    body_byte = num_reg;
                    3'd4:    body_byte = {4'd0, exp_reg};
                    3'd5:    body_byte = clocks_per_click;
                    default: body_byte = thirty_seconds_per_quarter;
                endcase
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (evt.operation == OP_TEMPO) ? ST_DIVIDE : ST_VLQ;
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                    state_next = ST_VLQ;
            end
            ST_VLQ:
            begin
                if (emit_ok && vlq_cnt_reg == 2'd0)
                    state_next = ST_BODY;
            end
            ST_BODY:
            begin
                if (emit_ok && idx_reg == body_last_idx)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        evt.ready       = 1'b0;
        emit            = 1'b0;
        emit_byte       = body_byte;
        emit_last       = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = (evt.tempo_bpm == '0) ? BPM_W'(1) : evt.tempo_bpm;
        unique case (state_reg)
            ST_IDLE:
            begin
                evt.ready     = 1'b1;
                div_req.start = evt.valid && (evt.operation == OP_TEMPO);
            end
            ST_DIVIDE:
            begin
            end
            ST_VLQ:
            begin
                emit      = emit_ok;
                emit_byte = {vlq_cnt_reg != 2'd0, vlq_reg[DELTA_W-1 -: GROUP_W]};
            end
            ST_BODY:
            begin
                emit      = emit_ok;
                emit_last = idx_reg == body_last_idx;
            end
        endcase
    end

    always_comb
    begin
        vlq_next     = vlq_reg;
        vlq_cnt_next = vlq_cnt_reg;
        idx_next     = idx_reg;
        if (accept)
        begin
            vlq_cnt_next = groups_m1;
            idx_next     = '0;
            // Left-align so the top group sits in the upper seven bits.
            case (groups_m1)
                2'd3:    vlq_next = evt.delta_time;
                2'd2:    vlq_next = evt.delta_time << GROUP_W;
                2'd1:    vlq_next = evt.delta_time << (2 * GROUP_W);
                default: vlq_next = evt.delta_time << (3 * GROUP_W);
            endcase
        end
        else if (emit && state_reg == ST_VLQ)
        begin
            vlq_next     = vlq_reg << GROUP_W;
            vlq_cnt_next = vlq_cnt_reg - 2'd1;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !stream.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vlq_reg      <= vlq_next;
        vlq_cnt_reg  <= vlq_cnt_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            op_reg    <= evt.operation;
            chan_reg  <= evt.channel;
            pitch_reg <= evt.pitch;
            vel_reg   <= evt.velocity;
            num_reg   <= evt.numerator;
            exp_reg   <= denom_exponent(evt.denominator);
        end
    end

    assign stream.valid    = out_valid_reg;
    assign stream.out_byte = out_byte_reg;
    assign stream.last     = out_last_reg;

endmodule

/* design/midi_event_byte_serializer.sv */
// MIDI event byte serializer, top level: config registers, sequencer, divider.
// Depends on mebs_pkg, mebs_ifs, mebs_divider, mebs_sequencer and the macro header.
// The first byte is registered once the sequencer reaches its VLQ state; a tempo event
// first waits in the divide state for the bit-serial divide. A new event is taken only
// in the idle state; bytes go out one per cycle while the byte stream is ready.
// Reset: asynchronous active low; idle, no output, clock registers at 24 and 8.
`include "midi_event_byte_serializer_macros.svh"

module midi_event_byte_serializer (
    input  logic         clk,
    input  logic         rst_n,
    mebs_event_if.sink   evt,
    mebs_byte_if.source  stream,
    mebs_cfg_if.sink     cfg
);
    import mebs_pkg::*;

    logic [7:0] clocks_per_click_reg;
    logic [7:0] thirty_seconds_reg;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clocks_per_click_reg <= CLOCKS_PER_CLICK_RST;
            thirty_seconds_reg   <= THIRTY_SECONDS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_CLOCKS_PER_CLICK: clocks_per_click_reg <= cfg.data;
                CFG_THIRTY_SECONDS:   thirty_seconds_reg   <= cfg.data;
            endcase
        end
    end

    mebs_sequencer u_seq (
        .clk                        (clk),
        .rst_n                      (rst_n),
        .evt                        (evt),
        .stream                     (stream),
        .clocks_per_click           (clocks_per_click_reg),
        .thirty_seconds_per_quarter (thirty_seconds_reg),
        .div_req                    (div_req),
        .div_rsp                    (div_rsp)
    );

    mebs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    `MEBS_ASSERT_NEXT(a_busy_after_accept, evt.valid && evt.ready, !evt.ready, "ready after transfer")
    `MEBS_ASSERT_NOW(a_tempo_starts_div, evt.valid && evt.ready && evt.operation == OP_TEMPO, div_req.start, "tempo without divide")
    `MEBS_ASSERT_NOW(a_done_while_busy, div_rsp.done, !evt.ready, "divide done while idle")
    `MEBS_ASSERT_NEXT(a_div_not_instant, div_req.start, !div_rsp.done, "divide finished early")

endmodule

/* tb/mebs_byte_checker.sv */
// Checker for the MIDI event byte serializer: watches event, config and byte channels,
// predicts the byte stream of each event and compares every byte transfer in order.
// Depends on mebs_pkg and mebs_ifs.
module mebs_byte_checker (
    input  logic  clk,
    input  logic  rst_n,
    mebs_event_if evt,
    mebs_byte_if  stream,
    mebs_cfg_if   cfg,
    output int    fail_count,
    output int    pending
);
    import mebs_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } smf_byte_t;

    smf_byte_t  expected_bytes[$];
    logic [7:0] clocks_per_click_q;
    logic [7:0] thirty_seconds_q;
    int         mismatches;

    assign fail_count = mismatches;

    // Smallest k with den^2 < 2^(2k+1); zero maps to zero.
    function automatic logic [7:0] rounded_log2(input logic [7:0] den);
        int unsigned square;
        int unsigned k;
        square = den * den;
        k = 0;
        while (k < 16 && square > (32'd1 << (2 * k + 1)))
        begin
            k++;
        end
        return 8'(k);
    endfunction

    function automatic void encode_event(
        input op_t         operation,
        input logic [27:0] delta,
        input logic [3:0]  channel,
        input logic [6:0]  pitch,
        input logic [6:0]  velocity,
        input logic [9:0]  bpm,
        input logic [7:0]  numerator,
        input logic [7:0]  denominator
    );
        logic [7:0]  smf[11];
        int          count;
        int          groups;
        int unsigned usec_per_beat;
        smf_byte_t   entry;
        if (delta[27:21] != 0)
            groups = 4;
        else if (delta[20:14] != 0)
            groups = 3;
        else if (delta[13:7] != 0)
            groups = 2;
        else
            groups = 1;
        count = 0;
        for (int g = groups - 1; g >= 0; g--)
        begin
            smf[count] = {(g > 0), 7'(delta >> (7 * g))};
            count++;
        end
        case (operation)
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                smf[count]     = {(operation == OP_NOTE_ON) ? NOTE_ON_HI : NOTE_OFF_HI, channel};
                smf[count + 1] = {1'b0, pitch};
                smf[count + 2] = {1'b0, velocity};
                count += 3;
            end
            OP_TEMPO:
            begin
                usec_per_beat  = 32'(USEC_PER_MINUTE) / ((bpm == 0) ? 32'd1 : 32'(bpm));
                smf[count]     = META_PREFIX;
                smf[count + 1] = META_TEMPO;
                smf[count + 2] = TEMPO_LEN;
                smf[count + 3] = usec_per_beat[23:16];
                smf[count + 4] = usec_per_beat[15:8];
                smf[count + 5] = usec_per_beat[7:0];
                count += 6;
            end
            default:
            begin
                smf[count]     = META_PREFIX;
                smf[count + 1] = META_TIMESIG;
                smf[count + 2] = TIMESIG_LEN;
                smf[count + 3] = numerator;
                smf[count + 4] = rounded_log2(denominator);
                smf[count + 5] = clocks_per_click_q;
                smf[count + 6] = thirty_seconds_q;
                count += 7;
            end
        endcase
        for (int i = 0; i < count; i++)
        begin
            entry.value = smf[i];
            entry.last  = (i == count - 1);
            expected_bytes.insert(expected_bytes.size(), entry);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        smf_byte_t want;
        if (!rst_n)
        begin
            clocks_per_click_q <= CLOCKS_PER_CLICK_RST;
            thirty_seconds_q   <= THIRTY_SECONDS_RST;
            expected_bytes.delete();
            mismatches = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CLOCKS_PER_CLICK: clocks_per_click_q <= cfg.data;
                    CFG_THIRTY_SECONDS:   thirty_seconds_q   <= cfg.data;
                    default: ;
                endcase
            end
            // A byte transfer always belongs to an earlier event, so pop before push.
            if (stream.valid && stream.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte transfer: out_byte %h last %b",
                           stream.out_byte, stream.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (stream.out_byte !== want.value)
                    begin
                        $error("out_byte: expected %h, actual %h", want.value, stream.out_byte);
                        mismatches++;
                    end
                    if (stream.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, stream.last);
                        mismatches++;
                    end
                end
            end
            if (evt.valid && evt.ready)
            begin
                encode_event(evt.operation, evt.delta_time, evt.channel, evt.pitch,
                             evt.velocity, evt.tempo_bpm, evt.numerator, evt.denominator);
            end
            pending <= expected_bytes.size();
        end
    end

endmodule

/* tb/tb_midi_event_byte_serializer.sv */
// Testbench top for the MIDI event byte serializer: clock, reset, event and config
// stimulus, random backpressure on the byte stream, and the final verdict.
// Depends on mebs_pkg, mebs_ifs, the serializer RTL and mebs_byte_checker.
module tb_midi_event_byte_serializer;
    import mebs_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_EVENTS  = 43;
    localparam int RANDOM_PHASES = 6;

    typedef struct {
        op_t         operation;
        logic [27:0] delta;
        logic [3:0]  channel;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [9:0]  bpm;
        logic [7:0]  numerator;
        logic [7:0]  denominator;
    } midi_event_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    bit   steady;

    mebs_event_if evt_if ();
    mebs_byte_if  byte_if ();
    mebs_cfg_if   cfg_if ();

    midi_event_byte_serializer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt_if),
        .stream (byte_if),
        .cfg    (cfg_if)
    );

    mebs_byte_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt        (evt_if),
        .stream     (byte_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic midi_event_t random_event();
        midi_event_t e;
        int          width;
        width         = $urandom_range(0, 28);
        e.operation   = op_t'($urandom_range(0, 3));
        e.delta       = 28'($urandom) >> (28 - width);
        e.channel     = 4'($urandom);
        e.pitch       = 7'($urandom);
        e.velocity    = 7'($urandom);
        e.bpm         = 10'($urandom);
        e.numerator   = 8'($urandom);
        e.denominator = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 16)) : 8'($urandom);
        return e;
    endfunction

    function automatic midi_event_t note_event(input op_t op, input logic [27:0] delta,
                                               input logic [3:0] channel,
                                               input logic [6:0] pitch,
                                               input logic [6:0] velocity);
        midi_event_t e;
        e           = random_event();
        e.operation = op;
        e.delta     = delta;
        e.channel   = channel;
        e.pitch     = pitch;
        e.velocity  = velocity;
        return e;
    endfunction

    function automatic midi_event_t tempo_event(input logic [27:0] delta,
                                                input logic [9:0] bpm);
        midi_event_t e;
        e           = random_event();
        e.operation = OP_TEMPO;
        e.delta     = delta;
        e.bpm       = bpm;
        return e;
    endfunction

    function automatic midi_event_t timesig_event(input logic [27:0] delta,
                                                  input logic [7:0] numerator,
                                                  input logic [7:0] denominator);
        midi_event_t e;
        e             = random_event();
        e.operation   = OP_TIMESIG;
        e.delta       = delta;
        e.numerator   = numerator;
        e.denominator = denominator;
        return e;
    endfunction

    // Valid stays high across back-to-back transfers; it drops only for a gap.
    task automatic send_event(input midi_event_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_if.valid       <= 1'b1;
        evt_if.operation   <= item.operation;
        evt_if.delta_time  <= item.delta;
        evt_if.channel     <= item.channel;
        evt_if.pitch       <= item.pitch;
        evt_if.velocity    <= item.velocity;
        evt_if.tempo_bpm   <= item.bpm;
        evt_if.numerator   <= item.numerator;
        evt_if.denominator <= item.denominator;
        do @(posedge clk); while (!evt_if.ready);
    endtask

    task automatic wait_until_idle();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic program_clock_bytes(input logic [7:0] clicks, input logic [7:0] thirty);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_CLOCKS_PER_CLICK;
        cfg_if.data  <= clicks;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_THIRTY_SECONDS;
        cfg_if.data  <= thirty;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Byte stream sink: random stall before each transfer.
    initial
    begin
        int stall;
        byte_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                byte_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            byte_if.ready <= 1'b1;
            do @(posedge clk); while (!byte_if.valid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        steady              = 1'b0;
        rst_n              <= 1'b0;
        evt_if.valid       <= 1'b0;
        evt_if.operation   <= OP_NOTE_ON;
        evt_if.delta_time  <= '0;
        evt_if.channel     <= '0;
        evt_if.pitch       <= '0;
        evt_if.velocity    <= '0;
        evt_if.tempo_bpm   <= '0;
        evt_if.numerator   <= '0;
        evt_if.denominator <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_CLOCKS_PER_CLICK;
        cfg_if.data        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: VLQ group boundaries, field extremes, tempo and denominator corners,
        // all with the clock bytes still at their reset values.
        send_event(note_event(OP_NOTE_ON, 28'd0, 4'd0, 7'd0, 7'd0));
        send_event(note_event(OP_NOTE_ON, 28'd127, 4'd15, 7'd127, 7'd127));
        send_event(note_event(OP_NOTE_OFF, 28'd128, 4'd9, 7'd60, 7'd64));
        send_event(note_event(OP_NOTE_OFF, 28'd16383, 4'd15, 7'd127, 7'd0));
        send_event(note_event(OP_NOTE_ON, 28'd16384, 4'd1, 7'd1, 7'd1));
        send_event(note_event(OP_NOTE_ON, 28'd2097151, 4'd7, 7'd64, 7'd100));
        send_event(note_event(OP_NOTE_OFF, 28'd2097152, 4'd0, 7'd0, 7'd127));
        send_event(note_event(OP_NOTE_ON, 28'h0FFFFFF, 4'd15, 7'd127, 7'd127));
        send_event(note_event(OP_NOTE_ON, 28'hFFFFFFF, 4'd15, 7'd127, 7'd127));
        send_event(tempo_event(28'd0, 10'd0));
        send_event(tempo_event(28'd96, 10'd1));
        send_event(tempo_event(28'd480, 10'd120));
        send_event(tempo_event(28'd0, 10'd1023));
        send_event(tempo_event(28'hFFFFFFF, 10'd512));
        send_event(timesig_event(28'd0, 8'd4, 8'd4));
        send_event(timesig_event(28'd1, 8'd0, 8'd0));
        send_event(timesig_event(28'd0, 8'd255, 8'd1));
        send_event(timesig_event(28'd200, 8'd3, 8'd2));
        send_event(timesig_event(28'd0, 8'd6, 8'd3));
        send_event(timesig_event(28'd0, 8'd7, 8'd5));
        send_event(timesig_event(28'd0, 8'd12, 8'd6));
        send_event(timesig_event(28'd0, 8'd9, 8'd181));
        send_event(timesig_event(28'd0, 8'd9, 8'd182));
        send_event(timesig_event(28'hFFFFFFF, 8'd255, 8'd255));
        wait_until_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: program_clock_bytes(8'd0, 8'd0);
                1: program_clock_bytes(8'd255, 8'd255);
                3: program_clock_bytes(8'd0, 8'd255);
                4: program_clock_bytes(8'd255, 8'd0);
                5: program_clock_bytes(8'd24, 8'd8);
                default: program_clock_bytes(8'($urandom), 8'($urandom));
            endcase
            for (int n = 0; n < PHASE_EVENTS; n++)
            begin
                if ($urandom_range(0, 11) == 0)
                    steady = !steady;
                send_event(random_event());
            end
            wait_until_idle();
        end

        steady = 1'b0;
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
